### rtl/core/range_to_prefix_blocks_unit_defines.svh
// Assertion macros shared by the range-to-prefix RTL.
`ifndef RANGE_TO_PREFIX_BLOCKS_UNIT_DEFINES_SVH
`define RANGE_TO_PREFIX_BLOCKS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rtpb_pkg.sv
// Shared constants and control/status types for the range-to-prefix unit.
package rtpb_pkg;

  localparam int unsigned AddrBitsDefault = 32;
  localparam int unsigned AddrPortW       = 32;
  localparam int unsigned LenW            = 6;

  // Sequencer commands to the shared datapath.
  typedef struct packed {
    logic load;   // take a new request
    logic emit;   // advance cursor past the current block
    logic step;   // lower the exponent by one
  } rtpb_ctrl_t;

  // Datapath status back to the sequencer.
  typedef struct packed {
    logic diff_zero;  // cursor has reached the bound
    logic lead_set;   // remaining distance has its bit at the exponent set
    logic next_zero;  // emitting now brings the cursor to the bound
    logic exp_zero;
  } rtpb_stat_t;

endpackage

### rtl/core/rtpb_datapath.sv
// Shared cursor / distance / exponent datapath for prefix block extraction.
module rtpb_datapath import rtpb_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  rtpb_ctrl_t           ctrl_i,
  input  logic [AddrPortW-1:0] range_start_i,
  input  logic [AddrPortW-1:0] range_end_i,
  output rtpb_stat_t           stat_o,
  output logic [AddrPortW-1:0] cursor_o,
  output logic [AddrPortW-1:0] bound_o,
  output logic [LenW-1:0]      blk_len_o
);

  localparam int unsigned ExpW    = $clog2(AddrBits);
  localparam int unsigned LenIntW = $clog2(AddrBits + 1);

  logic [AddrBits-1:0] cursor_q, bound_q, diff_q;
  logic [ExpW-1:0]     exp_q;

  logic [AddrBits-1:0] addr_a, addr_b, lo, hi;
  logic [AddrBits-1:0] host, cur_next, diff_next;
  logic [LenIntW-1:0]  len_full;

  assign addr_a = AddrBits'(range_start_i);
  assign addr_b = AddrBits'(range_end_i);
  assign lo     = (addr_b < addr_a) ? addr_b : addr_a;
  assign hi     = (addr_b < addr_a) ? addr_a : addr_b;

  assign host     = ~({AddrBits{1'b1}} << exp_q);
  assign cur_next = (cursor_q | host) + AddrBits'(1);
  // bound - cur_next, written as one add: diff - (~cursor & host) - 1
  assign diff_next = diff_q + (cursor_q | ~host);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cursor_q <= lo;
      bound_q  <= hi;
      diff_q   <= hi - lo;
      exp_q    <= ExpW'(AddrBits - 1);
    end else if (ctrl_i.emit) begin
      cursor_q <= cur_next;
      diff_q   <= diff_next;
    end else if (ctrl_i.step) begin
      exp_q <= exp_q - ExpW'(1);
    end
  end

  assign stat_o.diff_zero = (diff_q == '0);
  assign stat_o.lead_set  = diff_q[exp_q];
  assign stat_o.next_zero = (diff_next == '0);
  assign stat_o.exp_zero  = (exp_q == '0);

  assign len_full  = LenIntW'(AddrBits) - LenIntW'(exp_q);
  assign blk_len_o = LenW'(len_full);
  assign cursor_o  = AddrPortW'(cursor_q);
  assign bound_o   = AddrPortW'(bound_q);

endmodule

### rtl/core/rtpb_outreg.sv
// Output register holding one result until the consumer takes it.
module rtpb_outreg import rtpb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [AddrPortW-1:0] push_addr_i,
  input  logic [LenW-1:0]      push_len_i,
  input  logic                 push_last_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AddrPortW-1:0] prefix_addr_o,
  output logic [LenW-1:0]      prefix_len_o,
  output logic                 last_of_run_o
);

  logic                 valid_q, valid_d;
  logic [AddrPortW-1:0] addr_q;
  logic [LenW-1:0]      len_q;
  logic                 last_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      addr_q <= push_addr_i;
      len_q  <= push_len_i;
      last_q <= push_last_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign prefix_addr_o = addr_q;
  assign prefix_len_o  = len_q;
  assign last_of_run_o = last_q;

endmodule

### rtl/core/rtpb_seq.sv
// Sequencer: request intake, exponent scan, block and end-entry issue.
`include "range_to_prefix_blocks_unit_defines.svh"
module rtpb_seq import rtpb_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  rtpb_stat_t           stat_i,
  output rtpb_ctrl_t           ctrl_o,
  input  logic [AddrPortW-1:0] cursor_i,
  input  logic [AddrPortW-1:0] bound_i,
  input  logic [LenW-1:0]      blk_len_i,
  input  logic                 out_ready_i,
  output logic                 push_o,
  output logic [AddrPortW-1:0] push_addr_o,
  output logic [LenW-1:0]      push_len_o,
  output logic                 push_last_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  localparam logic [LenW-1:0] EndLen = LenW'(AddrBits);

  logic state_q, state_d;
  logic end_pend_q, end_pend_d;
  logic end_en_q;
  logic accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    end_pend_d  = end_pend_q;
    ctrl_o      = '0;
    push_o      = 1'b0;
    push_addr_o = cursor_i;
    push_len_o  = blk_len_i;
    push_last_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          end_pend_d  = end_en_q;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (stat_i.diff_zero) begin
          if (!end_pend_q) begin
            state_d = StIdle;
          end else if (out_ready_i) begin
            push_o      = 1'b1;
            push_addr_o = bound_i;
            push_len_o  = EndLen;
            push_last_o = 1'b1;
            end_pend_d  = 1'b0;
            state_d     = StIdle;
          end
        end else if (stat_i.lead_set) begin
          if (out_ready_i) begin
            ctrl_o.emit = 1'b1;
            push_o      = 1'b1;
            push_last_o = stat_i.next_zero && !end_pend_q;
            if (push_last_o) begin
              state_d = StIdle;
            end
          end
        end else begin
          // distance below 2^exp: narrow the block size
          ctrl_o.step = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      end_pend_q <= 1'b0;
      end_en_q   <= 1'b1;
    end else begin
      state_q    <= state_d;
      end_pend_q <= end_pend_d;
      if (cfg_we_i) begin
        end_en_q <= cfg_wdata_i;
      end
    end
  end

  `RTPB_ASSERT_NOW(a_push_only_when_room, clk_i, rst_ni, push_o, out_ready_i, "push into full output register")
  `RTPB_ASSERT_NOW(a_no_push_idle, clk_i, rst_ni, state_q == StIdle, !push_o, "result issued while idle")
  `RTPB_ASSERT_NEXT(a_last_ends_run, clk_i, rst_ni, push_o && push_last_o, state_q == StIdle, "run continues after last result")
  `RTPB_ASSERT_NOW(a_step_no_underflow, clk_i, rst_ni, ctrl_o.step, !stat_i.exp_zero, "exponent underflow")
  `RTPB_ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni, accept, state_q == StScan, "accepted request did not start")

endmodule

### rtl/core/range_to_prefix_blocks_unit.sv
// Top level: address range to prefix block list converter.
//
//  port group   dir  handshake               payload
//  request      in   in_valid_i / in_stall_o range_start_i, range_end_i
//  result       out  out_valid_o/out_stall_i prefix_addr_o, prefix_len_o, last_of_run_o
//  config       in   cfg_we_i                cfg_wdata_i (end-entry enable)
//
// One request occupies the unit until its exponent scan and all of its results are done:
// the shared exponent scan walks down once per request (at most AddrBits-1 steps),
// each block advances the cursor through the single cursor adder, and the end entry is taken from the bound.
// in_stall_o stays high until the last result has entered the output register.
// A stalled consumer freezes the sequencer at its next result.
// After reset the unit is idle with the end entry enabled; no clearing pass is needed.
`include "range_to_prefix_blocks_unit_defines.svh"
module range_to_prefix_blocks_unit import rtpb_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [AddrPortW-1:0] range_start_i,
  input  logic [AddrPortW-1:0] range_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AddrPortW-1:0] prefix_addr_o,
  output logic [LenW-1:0]      prefix_len_o,
  output logic                 last_of_run_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  rtpb_ctrl_t           ctrl;
  rtpb_stat_t           stat;
  logic [AddrPortW-1:0] cursor, bound, push_addr;
  logic [LenW-1:0]      blk_len, push_len;
  logic                 push, push_last, out_ready;

  rtpb_datapath #(
    .AddrBits(AddrBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .stat_o       (stat),
    .cursor_o     (cursor),
    .bound_o      (bound),
    .blk_len_o    (blk_len)
  );

  rtpb_seq #(
    .AddrBits(AddrBits)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .cursor_i   (cursor),
    .bound_i    (bound),
    .blk_len_i  (blk_len),
    .out_ready_i(out_ready),
    .push_o     (push),
    .push_addr_o(push_addr),
    .push_len_o (push_len),
    .push_last_o(push_last)
  );

  rtpb_outreg u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_addr_i  (push_addr),
    .push_len_i   (push_len),
    .push_last_i  (push_last),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .prefix_addr_o(prefix_addr_o),
    .prefix_len_o (prefix_len_o),
    .last_of_run_o(last_of_run_o)
  );

  `RTPB_ASSERT_NOW(a_busy_while_output_loads, clk_i, rst_ni, push, in_stall_o, "result issued without a request in flight")
  `RTPB_ASSERT_NEXT(a_push_shows_valid, clk_i, rst_ni, push, out_valid_o, "issued result not presented")
  `RTPB_ASSERT_NOW(a_len_in_range, clk_i, rst_ni, out_valid_o, prefix_len_o != '0 || AddrBits == 64, "zero prefix length")

endmodule

### tb/tb_range_to_prefix_blocks_unit.sv
// Self-checking testbench for the address range to prefix block converter.
module tb_range_to_prefix_blocks_unit;
  import rtpb_pkg::*;

  localparam int unsigned FULL_LEN = AddrBitsDefault;
  localparam int unsigned SETTLE   = 2 * AddrBitsDefault + 6;

  typedef logic [AddrPortW-1:0] addr_t;
  typedef logic [LenW-1:0]      len_t;

  typedef struct packed {
    addr_t addr;
    len_t  len;
    logic  last;
  } prefix_block_t;

  // typed rows carry their single result (or none); the rest go through the predictor
  typedef struct packed {
    addr_t      lo;
    addr_t      hi;
    logic       incl;
    logic       typed;
    logic [1:0] count;
    addr_t      addr;
    len_t       len;
  } range_row_t;

  localparam int N_ROWS = 22;
  localparam range_row_t RANGE_ROWS [N_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 2'd1, 32'h0000_0000, 6'd32},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd1, 32'hFFFF_FFFF, 6'd32},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0010, 32'h0000_0020, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0020, 32'h0000_0010, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h1234_5678, 32'h1234_5678, 1'b1, 1'b1, 2'd1, 32'h1234_5678, 6'd32},
    '{32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 2'd0, 32'h0, 6'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0100, 32'h0000_0101, 1'b0, 1'b1, 2'd1, 32'h0000_0100, 6'd32},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b1, 2'd1, 32'hFFFF_FFFE, 6'd32},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0001, 32'hFFFF_FFFE, 1'b0, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 2'd0, 32'h0, 6'd0}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  addr_t range_start_i = '0;
  addr_t range_end_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  addr_t prefix_addr_o;
  len_t  prefix_len_o;
  logic  last_of_run_o;
  logic  cfg_we_i = 1'b0;
  logic  cfg_wdata_i = 1'b0;

  prefix_block_t pending_blocks [$];
  bit            append_end = 1'b1;  // end-entry enable as last written
  bit            steady = 1'b0;      // no idling on either side while set
  int            mismatches = 0;

  range_to_prefix_blocks_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prefix_addr_o (prefix_addr_o),
    .prefix_len_o  (prefix_len_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Blocks for [lo, hi) as the unit walks them, cursor unmasked; end entry if enabled.
  function automatic void expand_range(input addr_t a, input addr_t b);
    addr_t cursor;
    addr_t bound;
    addr_t span;
    addr_t host;
    addr_t top;
    int    exp2;
    int    first;
    bit    stop;
    first  = pending_blocks.size();
    cursor = (b < a) ? b : a;
    bound  = (b < a) ? a : b;
    stop   = 1'b0;
    while (!stop && cursor < bound) begin
      span = bound - cursor;
      exp2 = 0;
      for (int i = 0; i < AddrPortW; i++)
        if (span[i]) exp2 = i;
      host = (exp2 == 0) ? '0 : ({AddrPortW{1'b1}} >> (AddrPortW - exp2));
      top  = cursor | host;
      pending_blocks.push_back('{cursor, len_t'(FULL_LEN - exp2), 1'b0});
      // block reaching the top address closes the run instead of wrapping
      if (top == {AddrPortW{1'b1}}) stop = 1'b1;
      else cursor = top + 1'b1;
    end
    if (append_end) pending_blocks.push_back('{bound, len_t'(FULL_LEN), 1'b0});
    if (pending_blocks.size() > first) pending_blocks[$].last = 1'b1;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_range(input addr_t lo, input addr_t hi, input bit typed,
                            input int count, input addr_t taddr, input len_t tlen);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    range_start_i <= lo;
    range_end_i   <= hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!typed) expand_range(lo, hi);
    else if (count > 0) pending_blocks.push_back('{taddr, tlen, 1'b1});
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    // an empty run may still be in flight after the last result
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_end_en(input bit value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    append_end = value;
  endtask

  task automatic random_range(output addr_t lo, output addr_t hi);
    addr_t tmp;
    int    sz;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        lo = $urandom;
        hi = $urandom;
      end
      4: begin
        lo = $urandom;
        hi = lo;
      end
      5: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 300);
      end
      6: begin
        lo = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        hi = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      end
      7: begin
        lo = $urandom_range(0, 5000);
        hi = $urandom_range(0, 100000);
      end
      8: begin
        // aligned power-of-two block, the exact-cover case
        sz = $urandom_range(0, 31);
        lo = $urandom & ~((addr_t'(1) << sz) - 1'b1);
        hi = lo + ((addr_t'(1) << sz) - 1'b1);
      end
      default: begin
        lo = $urandom_range(0, 1) ? '0 : $urandom;
        hi = $urandom_range(0, 1) ? '1 : $urandom;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
  endtask

  always @(negedge clk_i)
    out_stall_i <= !steady && ($urandom_range(0, 99) < 18);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr=%h len=%0d last=%b",
                   prefix_addr_o, prefix_len_o, last_of_run_o);
      end else begin
        if (pending_blocks[0] !=
            prefix_block_t'{prefix_addr_o, prefix_len_o, last_of_run_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%h len=%0d last=%b, got addr=%h len=%0d last=%b",
                     pending_blocks[0].addr, pending_blocks[0].len, pending_blocks[0].last,
                     prefix_addr_o, prefix_len_o, last_of_run_o);
        end
        void'(pending_blocks.pop_front());
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    addr_t lo;
    addr_t hi;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (RANGE_ROWS[r]) begin
      if (RANGE_ROWS[r].incl != append_end) write_end_en(RANGE_ROWS[r].incl);
      send_range(RANGE_ROWS[r].lo, RANGE_ROWS[r].hi, RANGE_ROWS[r].typed,
                 RANGE_ROWS[r].count, RANGE_ROWS[r].addr, RANGE_ROWS[r].len);
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_end_en(phase[0]);
      for (int n = 0; n < 55; n++) begin
        steady = (phase == 2) && (n >= 10);
        random_range(lo, hi);
        send_range(lo, hi, 1'b0, 0, '0, '0);
      end
      steady = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    mismatches += pending_blocks.size();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### range_to_prefix_blocks_unit.f
+incdir+rtl/core
rtl/core/rtpb_pkg.sv
rtl/core/rtpb_datapath.sv
rtl/core/rtpb_outreg.sv
rtl/core/rtpb_seq.sv
rtl/core/range_to_prefix_blocks_unit.sv
tb/tb_range_to_prefix_blocks_unit.sv
